>>> rtl/rbsi_pkg.sv
// ----------------------------------------------------------------------------
// rbsi_pkg
// Shared types and constants of the ray versus box slab test.
// ----------------------------------------------------------------------------
package rbsi_pkg;

   // Width of the reported distance, Q15.16 unsigned.
   localparam int DIST_W = 31;

   // Register index width and register map.
   localparam int CSR_ADDR_W = 3;
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_BOX_MIN_X = 3'd0,
      REG_BOX_MIN_Y = 3'd1,
      REG_BOX_MIN_Z = 3'd2,
      REG_BOX_MAX_X = 3'd3,
      REG_BOX_MAX_Y = 3'd4,
      REG_BOX_MAX_Z = 3'd5,
      REG_MAX_DIST  = 3'd6
   } csr_reg_type;

   // Reset value of the distance limit: 1000.0 in Q15.16.
   localparam logic [DIST_W-1:0] MAX_DIST_RST = 31'd65536000;

   // Per-axis flags carried alongside the divider chain.
   typedef struct packed {
      logic dzero;   // direction component is zero, ray parallel to slab
      logic pin;     // origin lies within the slab, boundary included
   } axis_flag_type;

endpackage

>>> rtl/ray_box_slab_intersect.sv
// ----------------------------------------------------------------------------
// ray_box_slab_intersect
// Ray against axis-aligned box, slab method, fully pipelined.
// ----------------------------------------------------------------------------
// One ray is taken every cycle while the output is not stalled, and one
// result word comes out per ray, in order. The pipeline is one input
// stage, a chain of COORD_WIDTH+FRAC_BITS+1 division cells per slab
// distance that each produce one quotient bit, then saturate/order, x/y
// narrowing and z narrowing with the final decision into the output
// register. The whole chain holds while a result waits to be taken. Write
// the box and distance limit only while no ray is in flight.
// ----------------------------------------------------------------------------
module ray_box_slab_intersect #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic clock,
   input  logic reset,
   // fields from bit 0: origin_x, origin_y, origin_z, dir_x, dir_y, dir_z
   input  logic                                      req_tvalid,
   output logic                                      req_tready,
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]        req_tdata,
   // fields from bit 0: hit, distance
   output logic                                      rsp_tvalid,
   input  logic                                      rsp_tready,
   output logic [rbsi_pkg::DIST_W:0]                 rsp_tdata,
   // configuration write port
   input  logic                                      csr_we,
   input  logic [rbsi_pkg::CSR_ADDR_W-1:0]           csr_addr,
   input  logic [(COORD_WIDTH>31?COORD_WIDTH:31)-1:0] csr_wdata
);
   import rbsi_pkg::*;

   localparam int C  = COORD_WIDTH;
   localparam int NW = C + 1 + FRAC_BITS;          // dividend / quotient width
   localparam int EW = (C > 32 ? C : 32) + 1;      // compare width vs limit

   // ---------------------------------------------------------------- config
   logic signed [C-1:0]  box_min_ff [3];
   logic signed [C-1:0]  box_max_ff [3];
   logic [DIST_W-1:0]    max_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            box_min_ff[a] <= '0;
            box_max_ff[a] <= '0;
         end
         max_dist_ff <= MAX_DIST_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_BOX_MIN_X: box_min_ff[0] <= csr_wdata[C-1:0];
            REG_BOX_MIN_Y: box_min_ff[1] <= csr_wdata[C-1:0];
            REG_BOX_MIN_Z: box_min_ff[2] <= csr_wdata[C-1:0];
            REG_BOX_MAX_X: box_max_ff[0] <= csr_wdata[C-1:0];
            REG_BOX_MAX_Y: box_max_ff[1] <= csr_wdata[C-1:0];
            REG_BOX_MAX_Z: box_max_ff[2] <= csr_wdata[C-1:0];
            REG_MAX_DIST:  max_dist_ff   <= csr_wdata[DIST_W-1:0];
            default: ;     // drop writes beyond the register map
         endcase
      end
   end

   // ------------------------------------------------------------ flow control
   // Every stage moves together; hold all of them while a result is refused.
   logic en;
   logic rsp_tvalid_ff, rsp_tvalid_in;
   assign en         = ~rsp_tvalid_ff | rsp_tready;
   assign req_tready = en;

   // valid of input stage and of each cell output
   logic [NW:0] vld_ff;
   logic        vld_f1_ff, vld_f2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff        <= '0;
         vld_f1_ff     <= 1'b0;
         vld_f2_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else if (en) begin
         vld_ff        <= {vld_ff[NW-1:0], req_tvalid};
         vld_f1_ff     <= vld_ff[NW];
         vld_f2_ff     <= vld_f1_ff;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end
   assign rsp_tvalid_in = vld_f2_ff;

   // ------------------------------------------------------------ input stage
   // Lane 2a divides (min - origin), lane 2a+1 divides (max - origin), axis a.
   logic [NW-1:0] acc_w [6][NW+1];
   logic [C-1:0]  rem_w [6][NW+1];
   logic [C-1:0]  div_w [6][NW+1];
   logic          neg_w [6][NW+1];
   axis_flag_type flg_ff [NW+1][3];

   logic [NW-1:0] acc0_in [6];
   logic [C-1:0]  div0_in [6];
   logic          neg0_in [6];
   axis_flag_type flg0_in [3];
   logic [NW-1:0] acc0_ff [6];
   logic [C-1:0]  div0_ff [6];
   logic          neg0_ff [6];

   always_comb begin
      logic signed [C-1:0] org, dir, bnd;
      logic [C:0]          diff, mag;
      for (int l = 0; l < 6; l++) begin
         org  = req_tdata[(l/2)*C +: C];
         dir  = req_tdata[(3+l/2)*C +: C];
         bnd  = l[0] ? box_max_ff[l/2] : box_min_ff[l/2];
         diff = {bnd[C-1], bnd} - {org[C-1], org};
         mag  = diff[C] ? -diff : diff;
         acc0_in[l] = {mag, {FRAC_BITS{1'b0}}};
         div0_in[l] = dir[C-1] ? -dir : dir;
         neg0_in[l] = diff[C] ^ dir[C-1];
      end
      for (int a = 0; a < 3; a++) begin
         org = req_tdata[a*C +: C];
         dir = req_tdata[(3+a)*C +: C];
         flg0_in[a].dzero = (dir == '0);
         flg0_in[a].pin   = (org >= box_min_ff[a]) && (org <= box_max_ff[a]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int l = 0; l < 6; l++) begin
            acc0_ff[l] <= acc0_in[l];
            div0_ff[l] <= div0_in[l];
            neg0_ff[l] <= neg0_in[l];
         end
         for (int a = 0; a < 3; a++) begin
            flg_ff[0][a] <= flg0_in[a];
         end
         for (int k = 0; k < NW; k++) begin
            flg_ff[k+1] <= flg_ff[k];
         end
      end
   end

   // ------------------------------------------------------------ cell chain
   genvar gl, gk;
   generate
      for (gl = 0; gl < 6; gl++) begin : g_lane
         assign acc_w[gl][0] = acc0_ff[gl];
         assign rem_w[gl][0] = '0;
         assign div_w[gl][0] = div0_ff[gl];
         assign neg_w[gl][0] = neg0_ff[gl];
         for (gk = 0; gk < NW; gk++) begin : g_cell
            rbsi_div_cell #(.C(C), .NW(NW)) u_cell (
               .clock (clock),
               .en    (en),
               .rem_i (rem_w[gl][gk]),
               .acc_i (acc_w[gl][gk]),
               .div_i (div_w[gl][gk]),
               .neg_i (neg_w[gl][gk]),
               .rem_o (rem_w[gl][gk+1]),
               .acc_o (acc_w[gl][gk+1]),
               .div_o (div_w[gl][gk+1]),
               .neg_o (neg_w[gl][gk+1])
            );
         end
      end
   endgenerate

   // ------------------------------------------------ saturate and order slabs
   logic signed [C-1:0] near_w [3];
   logic signed [C-1:0] far_w  [3];
   logic                miss_w [3];

   genvar ga;
   generate
      for (ga = 0; ga < 3; ga++) begin : g_axis
         rbsi_slab_sort #(.C(C), .NW(NW)) u_sort (
            .clock  (clock),
            .en     (en),
            .qa_i   (acc_w[2*ga][NW]),
            .nega_i (neg_w[2*ga][NW]),
            .qb_i   (acc_w[2*ga+1][NW]),
            .negb_i (neg_w[2*ga+1][NW]),
            .flg_i  (flg_ff[NW][ga]),
            .near_o (near_w[ga]),
            .far_o  (far_w[ga]),
            .miss_o (miss_w[ga])
         );
      end
   endgenerate

   // ------------------------------------------------------- narrow x with y
   logic                ok2_in, ok2_ff;
   logic signed [C-1:0] tmin2_in, tmin2_ff, tmax2_in, tmax2_ff;
   logic signed [C-1:0] zn_ff, zf_ff;
   logic                zm_ff;

   always_comb begin
      ok2_in   = ~miss_w[0] & ~miss_w[1] &
                 ~(near_w[0] > far_w[1]) & ~(near_w[1] > far_w[0]);
      tmin2_in = (near_w[1] > near_w[0]) ? near_w[1] : near_w[0];
      tmax2_in = (far_w[1] < far_w[0]) ? far_w[1] : far_w[0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok2_ff   <= ok2_in;
         tmin2_ff <= tmin2_in;
         tmax2_ff <= tmax2_in;
         zn_ff    <= near_w[2];
         zf_ff    <= far_w[2];
         zm_ff    <= miss_w[2];
      end
   end

   // ------------------------------------------------ narrow with z, decide
   logic                ok3;
   logic signed [C-1:0] tmin3, tmax3;
   logic signed [EW-1:0] tmin_e, tmax_e, maxd_e;
   logic                hit_in, hit_ff;
   logic [DIST_W-1:0]   dist_in, dist_ff;

   always_comb begin
      ok3    = ok2_ff & ~zm_ff & ~(tmin2_ff > zf_ff) & ~(zn_ff > tmax2_ff);
      tmin3  = (zn_ff > tmin2_ff) ? zn_ff : tmin2_ff;
      tmax3  = (zf_ff < tmax2_ff) ? zf_ff : tmax2_ff;
      tmin_e = {{(EW-C){tmin3[C-1]}}, tmin3};
      tmax_e = {{(EW-C){tmax3[C-1]}}, tmax3};
      maxd_e = {{(EW-DIST_W){1'b0}}, max_dist_ff};
      hit_in  = 1'b0;
      dist_in = '0;
      if (ok3) begin
         if (tmin_e < 0 && tmax_e > 0) begin
            hit_in = 1'b1;              // origin inside the box
         end else if (tmin_e > 0 && tmin_e < maxd_e) begin
            hit_in  = 1'b1;
            dist_in = tmin_e[DIST_W-1:0];
         end else if (tmax_e > 0 && tmax_e < maxd_e) begin
            hit_in  = 1'b1;
            dist_in = tmax_e[DIST_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         hit_ff  <= hit_in;
         dist_ff <= dist_in;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {dist_ff, hit_ff};

   // ------------------------------------------------------------ assertions
   a_ready_tracks_stall: assert property (@(posedge clock) disable iff (reset)
      req_tready == (~rsp_tvalid | rsp_tready))
      else $error("input ready does not follow output stall");

   a_miss_zero_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[0]) |-> (rsp_tdata[DIST_W:1] == '0))
      else $error("miss reported with non-zero distance");

   a_dist_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0] && rsp_tdata[DIST_W:1] != '0)
         |-> (rsp_tdata[DIST_W:1] < max_dist_ff))
      else $error("hit distance not below limit");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

>>> rtl/rbsi_div_cell.sv
// ----------------------------------------------------------------------------
// rbsi_div_cell
// One restoring division step: shift in a dividend bit, subtract the divisor
// when it fits, and hand remainder, dividend/quotient word and sign onward.
// ----------------------------------------------------------------------------
module rbsi_div_cell #(
   parameter int C  = 32,
   parameter int NW = 49
) (
   input  logic          clock,
   input  logic          en,
   input  logic [C-1:0]  rem_i,
   input  logic [NW-1:0] acc_i,
   input  logic [C-1:0]  div_i,
   input  logic          neg_i,
   output logic [C-1:0]  rem_o,
   output logic [NW-1:0] acc_o,
   output logic [C-1:0]  div_o,
   output logic          neg_o
);
   logic [C:0]    trial;
   logic [C:0]    diff;
   logic          ge;
   logic [C-1:0]  rem_in, rem_ff;
   logic [NW-1:0] acc_in, acc_ff;
   logic [C-1:0]  div_ff;
   logic          neg_ff;

   always_comb begin
      trial  = {rem_i, acc_i[NW-1]};
      diff   = trial - {1'b0, div_i};
      ge     = ~diff[C];
      rem_in = ge ? diff[C-1:0] : trial[C-1:0];
      acc_in = {acc_i[NW-2:0], ge};
   end

   // advance only when the pipeline moves
   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         acc_ff <= acc_in;
         div_ff <= div_i;
         neg_ff <= neg_i;
      end
   end

   assign rem_o = rem_ff;
   assign acc_o = acc_ff;
   assign div_o = div_ff;
   assign neg_o = neg_ff;
endmodule

>>> rtl/rbsi_slab_sort.sv
// ----------------------------------------------------------------------------
// rbsi_slab_sort
// Sign and saturate the two slab quotients of one axis and put them in order.
// ----------------------------------------------------------------------------
module rbsi_slab_sort #(
   parameter int C  = 32,
   parameter int NW = 49
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [NW-1:0]           qa_i,
   input  logic                    nega_i,
   input  logic [NW-1:0]           qb_i,
   input  logic                    negb_i,
   input  rbsi_pkg::axis_flag_type flg_i,
   output logic signed [C-1:0]     near_o,
   output logic signed [C-1:0]     far_o,
   output logic                    miss_o
);
   import rbsi_pkg::*;

   localparam logic [NW-1:0] HALF = NW'(1) << (C-1);
   localparam logic signed [C-1:0] T_HI = {1'b0, {(C-1){1'b1}}};
   localparam logic signed [C-1:0] T_LO = {1'b1, {(C-1){1'b0}}};

   logic signed [C-1:0] ta, tb;
   logic signed [C-1:0] near_in, near_ff, far_in, far_ff;
   logic                miss_in, miss_ff;

   always_comb begin
      if (nega_i) begin
         ta = (qa_i > HALF) ? T_LO : -$signed(qa_i[C-1:0]);
      end else begin
         ta = (qa_i >= HALF) ? T_HI : $signed(qa_i[C-1:0]);
      end
      if (negb_i) begin
         tb = (qb_i > HALF) ? T_LO : -$signed(qb_i[C-1:0]);
      end else begin
         tb = (qb_i >= HALF) ? T_HI : $signed(qb_i[C-1:0]);
      end
      if (flg_i.dzero) begin
         near_in = T_LO;
         far_in  = T_HI;
         miss_in = ~flg_i.pin;
      end else begin
         near_in = (ta > tb) ? tb : ta;
         far_in  = (ta > tb) ? ta : tb;
         miss_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         near_ff <= near_in;
         far_ff  <= far_in;
         miss_ff <= miss_in;
      end
   end

   assign near_o = near_ff;
   assign far_o  = far_ff;
   assign miss_o = miss_ff;
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ray versus box slab test.
// ----------------------------------------------------------------------------
// Rays go in on the req_ stream and one hit word per ray comes back on rsp_.
// A local slab predictor, fed by a shadow copy of the box registers, gives
// the expected word. A short table of hand-picked rays follows rays at the
// reset box. Random phases follow, each with its own box and distance limit.
// Most random rays are aimed at a point of the box so that all three slabs
// get narrowed. The rest are raw noise, or rays parallel to a slab, often on
// a face. Both sides idle at random, but for one phase that runs flat out.
// ----------------------------------------------------------------------------
module tb;
   import rbsi_pkg::*;

   localparam logic [CSR_ADDR_W-1:0] REG_UNMAPPED = 3'd7;
   localparam longint T_MAX   = 64'sd2147483647;
   localparam longint T_MIN   = -64'sd2147483648;
   localparam int     ONE     = 65536;   // 1.0 in Q16.16
   localparam int     DRAIN   = 70;      // pipeline is 53 deep
   localparam int     PHASES  = 8;
   localparam int     PER_PH  = 130;

   // hit sits in bit 0, as on rsp_tdata
   typedef struct packed {
      logic [DIST_W-1:0] hit_dist;
      logic              hit;
   } hit_word_t;

   typedef struct {
      int ox, oy, oz, dx, dy, dz;
      bit typed;         // expected word written in the row
      bit hit;
      int hit_dist;
   } ray_row_t;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [191:0]            req_tdata;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [DIST_W:0]         rsp_tdata;
   logic                    csr_we;
   logic [CSR_ADDR_W-1:0]   csr_addr;
   logic [31:0]             csr_wdata;

   // shadow of the box registers
   logic signed [31:0] box_lo [3];
   logic signed [31:0] box_hi [3];
   logic [DIST_W-1:0]  dist_limit;

   hit_word_t pending_hits[$];
   int  mismatches;
   int  rays_sent;
   int  hits_seen;
   int  words_seen;
   bit  jitter_on;

   ray_box_slab_intersect dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #4ms;
      $display("timeout with %0d words outstanding", pending_hits.size());
      $display("tb failed");
      $finish;
   end

   // saturate a slab distance to the signed 32-bit range
   function automatic longint clamp_t(longint v);
      if (v > T_MAX) return T_MAX;
      if (v < T_MIN) return T_MIN;
      return v;
   endfunction

   // expected word for one ray against the current box
   function automatic hit_word_t trace_ray(logic [191:0] ray);
      longint tnear, tfar, n, f, lo, hi, org, dir, a, b, s, lim;
      bit ok;
      hit_word_t r;
      ok = 1'b1;
      tnear = 0;
      tfar = 0;
      r = '0;
      for (int ax = 0; ax < 3; ax++) begin
         if (ok) begin
            lo  = longint'(box_lo[ax]);
            hi  = longint'(box_hi[ax]);
            org = longint'(signed'(ray[ax*32 +: 32]));
            dir = longint'(signed'(ray[(ax+3)*32 +: 32]));
            if (dir == 0) begin
               // parallel: pass the slab only from inside it
               if (org < lo || org > hi) ok = 1'b0;
               n = T_MIN;
               f = T_MAX;
            end else begin
               a = clamp_t(((lo - org) * ONE) / dir);
               b = clamp_t(((hi - org) * ONE) / dir);
               if (a > b) begin
                  s = a; a = b; b = s;
               end
               n = a;
               f = b;
            end
            if (!ok) begin
            end else if (ax == 0) begin
               tnear = n;
               tfar = f;
            end else if (tnear > f || n > tfar) begin
               ok = 1'b0;
            end else begin
               if (n > tnear) tnear = n;
               if (f < tfar) tfar = f;
            end
         end
      end
      if (ok) begin
         lim = longint'(dist_limit);
         // tmin of exactly zero is not inside: fall through to tfar
         if (tnear < 0 && tfar > 0) begin
            r.hit = 1'b1;
         end else if (tnear > 0 && tnear < lim) begin
            r.hit = 1'b1;
            r.hit_dist = tnear[DIST_W-1:0];
         end else if (tfar > 0 && tfar < lim) begin
            r.hit = 1'b1;
            r.hit_dist = tfar[DIST_W-1:0];
         end
      end
      return r;
   endfunction

   // one register write; caller drops csr_we after the last one
   task automatic csr_write(logic [CSR_ADDR_W-1:0] addr, logic [31:0] v);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= v;
      case (addr)
         REG_BOX_MIN_X: box_lo[0] = v;
         REG_BOX_MIN_Y: box_lo[1] = v;
         REG_BOX_MIN_Z: box_lo[2] = v;
         REG_BOX_MAX_X: box_hi[0] = v;
         REG_BOX_MAX_Y: box_hi[1] = v;
         REG_BOX_MAX_Z: box_hi[2] = v;
         REG_MAX_DIST:  dist_limit = v[DIST_W-1:0];
         default: ;     // unmapped index, write is dropped
      endcase
      @(posedge clock);
   endtask

   task automatic set_box(int lx, int ly, int lz, int hx, int hy, int hz,
                          logic [31:0] lim);
      csr_write(REG_BOX_MIN_X, lx);
      csr_write(REG_BOX_MIN_Y, ly);
      csr_write(REG_BOX_MIN_Z, lz);
      csr_write(REG_BOX_MAX_X, hx);
      csr_write(REG_BOX_MAX_Y, hy);
      csr_write(REG_BOX_MAX_Z, hz);
      csr_write(REG_MAX_DIST, lim);
      // an unmapped index must leave every register alone
      csr_write(REG_UNMAPPED, $urandom);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // present one ray and hold it until taken
   task automatic send_ray(logic [191:0] ray, bit typed, hit_word_t typed_word);
      if (jitter_on && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_tdata  <= ray;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_hits.push_back(typed ? typed_word : trace_ray(ray));
      rays_sent++;
   endtask

   // wait for the pipe to empty before the box may change
   task automatic drain;
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_hits.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   // aim most rays at a point of the box, from somewhere near it
   function automatic logic [191:0] make_ray();
      logic [191:0] ray;
      longint lo, hi, span, tgt, org, dir;
      int pick;
      pick = $urandom_range(0, 99);
      for (int ax = 0; ax < 3; ax++) begin
         lo = longint'(box_lo[ax]);
         hi = longint'(box_hi[ax]);
         span = hi - lo + 1;
         tgt = (span > 0) ? lo + longint'($urandom) % span : lo;
         org = tgt + longint'($urandom_range(0, 39321600)) - 19660800;
         dir = (tgt - org) >>> $urandom_range(0, 10);
         if (pick < 15) begin
            org = $urandom;
            dir = $urandom;
         end else if ($urandom_range(0, 9) == 0) begin
            // parallel to this slab, often right on a face
            dir = 0;
            case ($urandom_range(0, 3))
               0: org = lo;
               1: org = hi;
               2: org = tgt;
               default: org = lo - 1;
            endcase
         end
         ray[ax*32 +: 32]     = org[31:0];
         ray[(ax+3)*32 +: 32] = dir[31:0];
      end
      return ray;
   endfunction

   function automatic logic [191:0] pack_row(ray_row_t r);
      return {r.dz, r.dy, r.dx, r.oz, r.oy, r.ox};
   endfunction

   // hand-picked rays against the box [-1,1]^3, limit 1000.0
   ray_row_t dir_rows[16] = '{
      // origin at the centre: inside
      '{0, 0, 0, ONE, 0, 0, 1, 1, 0},
      // straight on from -x: hit at 4.0
      '{-5*ONE, 0, 0, ONE, 0, 0, 1, 1, 4*ONE},
      // pointing away: both distances negative
      '{5*ONE, 0, 0, ONE, 0, 0, 1, 0, 0},
      // parallel to y slab, outside it
      '{-5*ONE, 5*ONE, 0, ONE, 0, 0, 1, 0, 0},
      // parallel to y slab, on its upper face
      '{-5*ONE, ONE, 0, ONE, 0, 0, 1, 1, 4*ONE},
      // parallel to z slab, on its lower face
      '{-5*ONE, 0, -ONE, ONE, 0, 0, 1, 1, 4*ONE},
      // origin on the near face: tmin zero, report far side
      '{-ONE, 0, 0, ONE, 0, 0, 1, 1, 2*ONE},
      // negative direction, distances swapped
      '{5*ONE, 0, 0, -ONE, 0, 0, 1, 1, 4*ONE},
      // tiny direction: both distances saturate high
      '{-5*ONE, 0, 0, 1, 0, 0, 1, 0, 0},
      // beyond the distance limit
      '{-2000*ONE, 0, 0, ONE, 0, 0, 1, 0, 0},
      // slabs disjoint between x and y
      '{-5*ONE, 5*ONE, 0, ONE, ONE, 0, 1, 0, 0},
      // zero direction, origin inside: whole range on every axis
      '{0, 0, 0, 0, 0, 0, 1, 1, 0},
      // extremes of the fields
      '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0},
      '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff,
        32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0},
      '{32'hffff_ffff, 0, 32'h8000_0000, -1, 32'h8000_0000, 1, 0, 0, 0},
      // diagonal from a corner
      '{-3*ONE, -3*ONE, -3*ONE, ONE, ONE, ONE, 1, 1, 2*ONE}
   };

   // receiver: stall at random while jitter is on
   always @(posedge clock) begin
      rsp_tready <= jitter_on ? ($urandom_range(0, 99) >= 12) : 1'b1;
   end

   // check every taken word against the oldest expectation
   always @(posedge clock) begin
      hit_word_t want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         words_seen++;
         if (pending_hits.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word hit=%0b dist=%0h", got.hit, got.hit_dist);
         end else begin
            want = pending_hits.pop_front();
            if (want.hit) hits_seen++;
            if (got.hit !== want.hit || got.hit_dist !== want.hit_dist) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("word %0d: want hit=%0b dist=%0h, got hit=%0b dist=%0h",
                           words_seen, want.hit, want.hit_dist, got.hit, got.hit_dist);
            end
         end
      end
   end

   initial begin
      hit_word_t w;
      int lx, ly, lz, hx, hy, hz;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = REG_BOX_MIN_X;
      csr_wdata  = '0;
      jitter_on  = 1'b1;
      mismatches = 0;
      rays_sent  = 0;
      hits_seen  = 0;
      words_seen = 0;
      for (int i = 0; i < 3; i++) begin
         box_lo[i] = '0;
         box_hi[i] = '0;
      end
      dist_limit = MAX_DIST_RST;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers straight out of reset: point box at the origin
      w = '0;
      for (int i = 0; i < 6; i++) send_ray(make_ray(), 1'b0, w);
      drain();

      set_box(-ONE, -ONE, -ONE, ONE, ONE, ONE, MAX_DIST_RST);
      foreach (dir_rows[i]) begin
         w.hit      = dir_rows[i].hit;
         w.hit_dist = DIST_W'(dir_rows[i].hit_dist);
         send_ray(pack_row(dir_rows[i]), dir_rows[i].typed, w);
      end
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         lx = -$urandom_range(1, 100) * ONE;
         ly = -$urandom_range(1, 100) * ONE;
         lz = -$urandom_range(1, 100) * ONE;
         hx = $urandom_range(0, 100) * ONE + $urandom_range(0, ONE);
         hy = $urandom_range(0, 100) * ONE;
         hz = $urandom_range(0, 100) * ONE;
         case (ph)
            0: set_box(lx, ly, lz, hx, hy, hz, MAX_DIST_RST);
            // widest box, largest limit (bit 31 written, must be dropped)
            1: set_box(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                       32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff);
            // zero limit: only inside rays hit
            2: set_box(lx, ly, lz, hx, hy, hz, 0);
            // reversed box on x
            3: set_box(hx + ONE, ly, lz, lx, hy, hz, 32'h7fff_ffff);
            // box away from the origin, short limit
            4: set_box(lx + 200*ONE, ly, lz, hx + 200*ONE, hy, hz, 150*ONE);
            default: set_box(lx, ly, lz, hx, hy, hz, $urandom_range(1, 32'h7fff_ffff));
         endcase
         // one phase runs with no idling on either side
         jitter_on = (ph != 5);
         w = '0;
         for (int i = 0; i < PER_PH; i++) send_ray(make_ray(), 1'b0, w);
         drain();
      end

      $display("%0d rays over %0d box settings, %0d hits, %0d mismatches",
               rays_sent, PHASES + 2, hits_seen, mismatches);
      if (mismatches == 0 && pending_hits.size() == 0) begin
         $display("tb passed");
      end else begin
         $display("tb failed");
      end
      $finish;
   end

endmodule

>>> sim.f
rtl/rbsi_pkg.sv
rtl/rbsi_div_cell.sv
rtl/rbsi_slab_sort.sv
rtl/ray_box_slab_intersect.sv
tb/sv/tb.sv
